[rtl/sgpb_pkg.sv]
// ---------------------------------------------------------------------------
// sgpb_pkg
// Shared widths, register indexes, operation codes and interface structs of
// the stereo gain / pan / bit crush block.
// ---------------------------------------------------------------------------
package sgpb_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int PEAK_W     = SAMPLE_W - 1;
	localparam int GAIN_W     = 20;
	localparam int GAIN_FRAC  = 16;
	localparam int PAN_W      = 18;
	localparam int PAN_FRAC   = 16;
	localparam int PANG_W     = PAN_FRAC + 1;
	localparam int SCALE_W    = 32;
	localparam int SCALE_FRAC = 8;
	localparam int STEP_W     = 33;
	localparam int STEP_FRAC  = 32;
	localparam int QNT_SHIFT  = SAMPLE_W - 1 + SCALE_FRAC;
	localparam int STEP_SHIFT = STEP_FRAC - (SAMPLE_W - 1);
	localparam int SHIFT_W    = 6;

	// magnitude after crush rebuild stays below 2^52
	localparam int MAG_W   = 52;
	localparam int MUL_A_W = STEP_W;
	localparam int MUL_B_W = 28;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int HALF_W  = GAIN_W;
	localparam int CLAMP_W = 2 * HALF_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = STEP_W;
	localparam int S_TDATA_W  = 2 * SAMPLE_W;
	localparam int M_FIELDS_W = 2 * SAMPLE_W + 4 * PEAK_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] REG_IN_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_POSITION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_BYPASS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRUSH_ENABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CRUSH_SCALE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CRUSH_STEP   = 3'd6;

	localparam logic [GAIN_W-1:0]  GAIN_UNITY      = GAIN_W'(1 << GAIN_FRAC);
	localparam logic [PANG_W-1:0]  PAN_ONE         = PANG_W'(1 << PAN_FRAC);
	localparam logic [SCALE_W-1:0] CRUSH_SCALE_RST = SCALE_W'(64'h8000_0000);
	localparam logic [STEP_W-1:0]  CRUSH_STEP_RST  = STEP_W'(512);

	typedef logic [2:0] op_t;
	localparam op_t OP_IN   = 3'd0;
	localparam op_t OP_PAN  = 3'd1;
	localparam op_t OP_QNT  = 3'd2;
	localparam op_t OP_STEP = 3'd3;
	localparam op_t OP_OLO  = 3'd4;
	localparam op_t OP_OHI  = 3'd5;

	localparam logic CH_L = 1'b0;
	localparam logic CH_R = 1'b1;

	typedef struct packed {
		logic [GAIN_W-1:0]  in_gain;
		logic [GAIN_W-1:0]  out_gain;
		logic [PAN_W-1:0]   pan_position;
		logic               pan_bypass;
		logic               crush_enable;
		logic [SCALE_W-1:0] crush_scale;
		logic [STEP_W-1:0]  crush_step;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic issue;
		op_t  op;
		logic ch;
		logic xfer;
	} cmd_t;

endpackage

[rtl/sgpb_cfg.sv]
// ---------------------------------------------------------------------------
// sgpb_cfg
// Configuration register file; pan position is clamped to +-1.0 on write.
// ---------------------------------------------------------------------------
module sgpb_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_valid,
	output logic                             wr_ready,
	input  logic [sgpb_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [sgpb_pkg::CFG_DATA_W-1:0]  wr_data,
	output sgpb_pkg::cfg_t                   cfg
);

	localparam logic signed [sgpb_pkg::PAN_W-1:0] PAN_MAX =
		sgpb_pkg::PAN_W'(1 << sgpb_pkg::PAN_FRAC);
	localparam logic signed [sgpb_pkg::PAN_W-1:0] PAN_MIN = -PAN_MAX;

	sgpb_pkg::cfg_t cfg_q;
	logic signed [sgpb_pkg::PAN_W-1:0] pan_raw;
	logic signed [sgpb_pkg::PAN_W-1:0] pan_clamped;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_comb begin
		pan_raw = $signed(wr_data[sgpb_pkg::PAN_W-1:0]);
		if (pan_raw > PAN_MAX) begin
			pan_clamped = PAN_MAX;
		end else if (pan_raw < PAN_MIN) begin
			pan_clamped = PAN_MIN;
		end else begin
			pan_clamped = pan_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_gain      <= sgpb_pkg::GAIN_UNITY;
			cfg_q.out_gain     <= sgpb_pkg::GAIN_UNITY;
			cfg_q.pan_position <= '0;
			cfg_q.pan_bypass   <= 1'b0;
			cfg_q.crush_enable <= 1'b0;
			cfg_q.crush_scale  <= sgpb_pkg::CRUSH_SCALE_RST;
			cfg_q.crush_step   <= sgpb_pkg::CRUSH_STEP_RST;
		end else if (wr_valid) begin
			unique case (wr_index)
				sgpb_pkg::REG_IN_GAIN: begin
					cfg_q.in_gain <= wr_data[sgpb_pkg::GAIN_W-1:0];
				end
				sgpb_pkg::REG_OUT_GAIN: begin
					cfg_q.out_gain <= wr_data[sgpb_pkg::GAIN_W-1:0];
				end
				sgpb_pkg::REG_PAN_POSITION: begin
					cfg_q.pan_position <= pan_clamped;
				end
				sgpb_pkg::REG_PAN_BYPASS: begin
					cfg_q.pan_bypass <= wr_data[0];
				end
				sgpb_pkg::REG_CRUSH_ENABLE: begin
					cfg_q.crush_enable <= wr_data[0];
				end
				sgpb_pkg::REG_CRUSH_SCALE: begin
					cfg_q.crush_scale <= wr_data[sgpb_pkg::SCALE_W-1:0];
				end
				sgpb_pkg::REG_CRUSH_STEP: begin
					cfg_q.crush_step <= wr_data[sgpb_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/sgpb_ctrl.sv]
// ---------------------------------------------------------------------------
// sgpb_ctrl
// Sequencer: issues one multiply per cycle, left and right interleaved, then
// hands the finished word to the output register.
// ---------------------------------------------------------------------------
module sgpb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 crush_enable,
	output sgpb_pkg::cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]          state_q;
	sgpb_pkg::op_t       op_q;
	logic                ch_q;
	logic                out_valid_q;
	sgpb_pkg::op_t       op_next;
	logic                accept;
	logic                out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		case (op_q)
			sgpb_pkg::OP_IN:   op_next = sgpb_pkg::OP_PAN;
			sgpb_pkg::OP_PAN:  op_next = crush_enable ? sgpb_pkg::OP_QNT : sgpb_pkg::OP_OLO;
			sgpb_pkg::OP_QNT:  op_next = sgpb_pkg::OP_STEP;
			sgpb_pkg::OP_STEP: op_next = sgpb_pkg::OP_OLO;
			sgpb_pkg::OP_OLO:  op_next = sgpb_pkg::OP_OHI;
			default:           op_next = sgpb_pkg::OP_IN;
		endcase
	end

	always_comb begin
		cmd.load  = accept;
		cmd.issue = (state_q == ST_RUN);
		cmd.op    = op_q;
		cmd.ch    = ch_q;
		cmd.xfer  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= sgpb_pkg::OP_IN;
			ch_q        <= sgpb_pkg::CH_L;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						op_q    <= sgpb_pkg::OP_IN;
						ch_q    <= sgpb_pkg::CH_L;
					end
				end
				ST_RUN: begin
					if (ch_q == sgpb_pkg::CH_R) begin
						ch_q <= sgpb_pkg::CH_L;
						if (op_q == sgpb_pkg::OP_OHI) begin
							state_q <= ST_DRAIN;
						end else begin
							op_q <= op_next;
						end
					end else begin
						ch_q <= sgpb_pkg::CH_R;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/sgpb_dp.sv]
// ---------------------------------------------------------------------------
// sgpb_dp
// Datapath: shared 33x28 multiplier, rounding stage, per-channel magnitude
// and sign, saturation, peak meters and the output register.
// ---------------------------------------------------------------------------
module sgpb_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sgpb_pkg::cfg_t                    cfg,
	input  sgpb_pkg::cmd_t                    cmd,
	input  logic [sgpb_pkg::S_TDATA_W-1:0]    in_data,
	input  logic                              in_stereo,
	input  logic                              in_last,
	output logic [sgpb_pkg::M_TDATA_W-1:0]    out_data,
	output logic                              out_peaks_valid
);

	localparam int SW  = sgpb_pkg::SAMPLE_W;
	localparam int PW  = sgpb_pkg::PEAK_W;
	localparam int MW  = sgpb_pkg::MAG_W;
	localparam int PRW = sgpb_pkg::PROD_W;
	localparam int HW  = sgpb_pkg::HALF_W;
	localparam int CW  = sgpb_pkg::CLAMP_W;
	localparam int PAD_W = sgpb_pkg::M_TDATA_W - sgpb_pkg::M_FIELDS_W;
	localparam logic [SW-1:0]  S_MAX   = {1'b0, {PW{1'b1}}};
	localparam logic [SW-1:0]  S_MIN   = {1'b1, {PW{1'b0}}};
	localparam logic [PRW-1:0] OUT_RND = PRW'(1) << (sgpb_pkg::GAIN_FRAC - 1);

	logic [MW-1:0]  mag_q [2];
	logic           neg_q [2];
	logic [CW-1:0]  acc_q [2];
	logic [SW-1:0]  res_q [2];
	logic [PW-1:0]  in_pk_q [2];
	logic [PW-1:0]  out_pk_q [2];
	logic           last_q;
	logic [sgpb_pkg::M_TDATA_W-1:0] out_data_q;
	logic           out_pv_q;

	logic [PRW-1:0]      prod_s1;
	sgpb_pkg::op_t       op_s1;
	logic                ch_s1;
	logic                vld_s1;

	logic [SW-1:0]  left_in, right_in, left_mag, right_mag;
	logic [MW-1:0]  mag_rd;
	logic [CW-1:0]  clamp_v;
	logic [sgpb_pkg::PANG_W-1:0] gain_l, gain_r, pang, pan_neg_mag;
	logic           pan_pos, pan_neg;
	logic [sgpb_pkg::MUL_A_W-1:0] mul_a;
	logic [sgpb_pkg::MUL_B_W-1:0] mul_b;

	logic [sgpb_pkg::SHIFT_W-1:0] rshift;
	logic [PRW:0]   rsum, rval;
	logic [PRW-1:0] osum, oval;
	logic [MW-1:0]  mag_new;
	logic           big, neg_rd;
	logic [PW-1:0]  cap;
	logic [SW-1:0]  sat_v;

	assign out_data        = out_data_q;
	assign out_peaks_valid = out_pv_q;

	// load: magnitude and sign of each channel
	always_comb begin
		left_in   = in_data[SW-1:0];
		right_in  = in_stereo ? in_data[2*SW-1:SW] : left_in;
		left_mag  = left_in[SW-1] ? (~left_in + 1'b1) : left_in;
		right_mag = right_in[SW-1] ? (~right_in + 1'b1) : right_in;
	end

	// pan gains: only the side opposite the pan direction drops
	always_comb begin
		pan_pos     = !cfg.pan_position[sgpb_pkg::PAN_W-1] && (|cfg.pan_position);
		pan_neg     = cfg.pan_position[sgpb_pkg::PAN_W-1];
		pan_neg_mag = sgpb_pkg::PANG_W'(~cfg.pan_position + 1'b1);
		gain_l = sgpb_pkg::PAN_ONE;
		gain_r = sgpb_pkg::PAN_ONE;
		if (!cfg.pan_bypass && pan_pos) begin
			gain_l = sgpb_pkg::PAN_ONE - cfg.pan_position[sgpb_pkg::PANG_W-1:0];
		end
		if (!cfg.pan_bypass && pan_neg) begin
			gain_r = sgpb_pkg::PAN_ONE - pan_neg_mag;
		end
	end

	// stage 1 operand select
	always_comb begin
		mag_rd  = mag_q[cmd.ch];
		clamp_v = (|mag_rd[MW-1:CW]) ? '1 : mag_rd[CW-1:0];
		pang    = (cmd.ch == sgpb_pkg::CH_R) ? gain_r : gain_l;
		case (cmd.op)
			sgpb_pkg::OP_IN: begin
				mul_a = sgpb_pkg::MUL_A_W'(cfg.in_gain);
				mul_b = mag_rd[sgpb_pkg::MUL_B_W-1:0];
			end
			sgpb_pkg::OP_PAN: begin
				mul_a = sgpb_pkg::MUL_A_W'(pang);
				mul_b = mag_rd[sgpb_pkg::MUL_B_W-1:0];
			end
			sgpb_pkg::OP_QNT: begin
				mul_a = sgpb_pkg::MUL_A_W'(cfg.crush_scale);
				mul_b = mag_rd[sgpb_pkg::MUL_B_W-1:0];
			end
			sgpb_pkg::OP_STEP: begin
				mul_a = cfg.crush_step;
				mul_b = mag_rd[sgpb_pkg::MUL_B_W-1:0];
			end
			sgpb_pkg::OP_OLO: begin
				mul_a = sgpb_pkg::MUL_A_W'(cfg.out_gain);
				mul_b = sgpb_pkg::MUL_B_W'(clamp_v[HW-1:0]);
			end
			sgpb_pkg::OP_OHI: begin
				mul_a = sgpb_pkg::MUL_A_W'(cfg.out_gain);
				mul_b = sgpb_pkg::MUL_B_W'(clamp_v[CW-1:HW]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// stage 2: round to nearest, ties away from zero (on the magnitude)
	always_comb begin
		case (op_s1)
			sgpb_pkg::OP_PAN:  rshift = sgpb_pkg::SHIFT_W'(sgpb_pkg::PAN_FRAC);
			sgpb_pkg::OP_QNT:  rshift = sgpb_pkg::SHIFT_W'(sgpb_pkg::QNT_SHIFT);
			sgpb_pkg::OP_STEP: rshift = sgpb_pkg::SHIFT_W'(sgpb_pkg::STEP_SHIFT);
			default:           rshift = sgpb_pkg::SHIFT_W'(sgpb_pkg::GAIN_FRAC);
		endcase
		rsum = {1'b0, prod_s1} + ((PRW+1)'(1) << (rshift - 1'b1));
		rval = rsum >> rshift;
		osum = PRW'(acc_q[ch_s1]) + (prod_s1 << HW) + OUT_RND;
		oval = osum >> sgpb_pkg::GAIN_FRAC;
		mag_new = (op_s1 == sgpb_pkg::OP_OHI) ? oval[MW-1:0] : rval[MW-1:0];
		big     = |mag_new[MW-1:PW];
		cap     = big ? '1 : mag_new[PW-1:0];
		neg_rd  = neg_q[ch_s1];
		if (big) begin
			sat_v = neg_rd ? S_MIN : S_MAX;
		end else if (neg_rd) begin
			sat_v = ~mag_new[SW-1:0] + 1'b1;
		end else begin
			sat_v = mag_new[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			in_pk_q[0]  <= '0;
			in_pk_q[1]  <= '0;
			out_pk_q[0] <= '0;
			out_pk_q[1] <= '0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.xfer && last_q) begin
				in_pk_q[0]  <= '0;
				in_pk_q[1]  <= '0;
				out_pk_q[0] <= '0;
				out_pk_q[1] <= '0;
			end else if (vld_s1) begin
				if (op_s1 == sgpb_pkg::OP_IN && cap > in_pk_q[ch_s1]) begin
					in_pk_q[ch_s1] <= cap;
				end
				if (op_s1 == sgpb_pkg::OP_OHI && cap > out_pk_q[ch_s1]) begin
					out_pk_q[ch_s1] <= cap;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		op_s1   <= cmd.op;
		ch_s1   <= cmd.ch;
		if (cmd.load) begin
			mag_q[0] <= MW'(left_mag);
			mag_q[1] <= MW'(right_mag);
			neg_q[0] <= left_in[SW-1];
			neg_q[1] <= right_in[SW-1];
			last_q   <= in_last;
		end else if (vld_s1) begin
			if (op_s1 == sgpb_pkg::OP_OLO) begin
				acc_q[ch_s1] <= prod_s1[CW-1:0];
			end else begin
				mag_q[ch_s1] <= mag_new;
			end
			if (op_s1 == sgpb_pkg::OP_OHI) begin
				res_q[ch_s1] <= sat_v;
			end
		end
		if (cmd.xfer) begin
			out_pv_q <= last_q;
			if (last_q) begin
				out_data_q <= {{PAD_W{1'b0}}, out_pk_q[1], out_pk_q[0],
					in_pk_q[1], in_pk_q[0], res_q[1], res_q[0]};
			end else begin
				out_data_q <= {{PAD_W{1'b0}}, {(4*PW){1'b0}}, res_q[1], res_q[0]};
			end
		end
	end

endmodule

[rtl/stereo_gain_pan_bitcrush.sv]
// ---------------------------------------------------------------------------
// stereo_gain_pan_bitcrush
// Stereo input gain, balance pan, optional bit crush, output gain and
// block peak meters for Q1.23 sample pairs.
// ---------------------------------------------------------------------------
// Input word (s_axis): tdata = left, right samples; tuser = stereo flag
// (0 copies left into right); tlast marks the last pair of a block.
// Output word (m_axis): both processed samples and, on the last pair of a
// block, the four peak meters with tuser (peaks valid) set; otherwise the
// peak fields are zero. The running peaks clear when that word is formed.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; the user is to
// write it only while the block is idle, which the block does not enforce; index 7 is ignored.
// Timing: one shared multiplier makes one product per cycle, left and right
// channel interleaved. With crush off a pair needs 8 products, with crush on
// 12. After the last product the sequencer passes its drain and done states
// and hands the result word to the output register; only then is the next
// input taken, so no new pair is taken before the last one reaches that register.
// Reset clears the sequencer, the peak meters and loads register defaults.
// If the receiver stalls, the result waits in the output register while one
// more pair is taken and computed; that pair then waits for the register.
// ---------------------------------------------------------------------------
module stereo_gain_pan_bitcrush (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [23:0] left_sample, [47:24] right_sample
	input  logic [sgpb_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// [0] stereo
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [23:0] left_out, [47:24] right_out, [70:48] in_peak_left,
	// [93:71] in_peak_right, [116:94] out_peak_left, [139:117] out_peak_right
	output logic [sgpb_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// [0] peaks_valid
	output logic                              m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sgpb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sgpb_pkg::CFG_DATA_W-1:0]   cfg_data
);

	sgpb_pkg::cfg_t cfg;
	sgpb_pkg::cmd_t cmd;

	sgpb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sgpb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.crush_enable (cfg.crush_enable),
		.cmd          (cmd)
	);

	sgpb_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.in_data         (s_axis_tdata),
		.in_stereo       (s_axis_tuser),
		.in_last         (s_axis_tlast),
		.out_data        (m_axis_tdata),
		.out_peaks_valid (m_axis_tuser)
	);

endmodule

[sim/sgpb_tb_pkg.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sgpb_tb_pkg
// Result prediction and checking for the stereo gain / pan / bit crush block:
// a bit-exact model of the gain, pan, crush and peak meter path keeps its own
// register copy and running peaks, queues one expected word per accepted
// sample pair and compares each output word field by field.
// ---------------------------------------------------------------------------
package sgpb_tb_pkg;

	import sgpb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam longint unsigned MAG_CEIL = 64'd1 << 62;
	localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_W - 1));
	localparam int PAN_UNIT = 65536;
	localparam int REPORT_MAX = 10;

	typedef logic [CFG_DATA_W-1:0] cfg_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left_out;
		logic [SAMPLE_W-1:0] right_out;
		logic [PEAK_W-1:0]   in_peak_left;
		logic [PEAK_W-1:0]   in_peak_right;
		logic [PEAK_W-1:0]   out_peak_left;
		logic [PEAK_W-1:0]   out_peak_right;
		logic                peaks_valid;
	} mix_word_t;

	class mix_scoreboard;
		longint unsigned   in_gain;
		longint unsigned   out_gain;
		int                pan_pos;
		bit                pan_bypass;
		bit                crush_enable;
		longint unsigned   crush_scale;
		longint unsigned   crush_step;
		longint unsigned   in_pk_l, in_pk_r, out_pk_l, out_pk_r;
		mix_word_t         pending[$];
		int                errors;

		function new();
			in_gain      = 64'(GAIN_UNITY);
			out_gain     = 64'(GAIN_UNITY);
			pan_pos      = 0;
			pan_bypass   = 1'b0;
			crush_enable = 1'b0;
			crush_scale  = 64'(CRUSH_SCALE_RST);
			crush_step   = 64'(CRUSH_STEP_RST);
			in_pk_l      = 0;
			in_pk_r      = 0;
			out_pk_l     = 0;
			out_pk_r     = 0;
			errors       = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t val);
			case (idx)
				REG_IN_GAIN:      in_gain = 64'(val[GAIN_W-1:0]);
				REG_OUT_GAIN:     out_gain = 64'(val[GAIN_W-1:0]);
				REG_PAN_POSITION: begin
					pan_pos = int'($signed(val[PAN_W-1:0]));
					if (pan_pos > PAN_UNIT) pan_pos = PAN_UNIT;
					if (pan_pos < -PAN_UNIT) pan_pos = -PAN_UNIT;
				end
				REG_PAN_BYPASS:   pan_bypass = val[0];
				REG_CRUSH_ENABLE: crush_enable = val[0];
				REG_CRUSH_SCALE:  crush_scale = 64'(val[SCALE_W-1:0]);
				REG_CRUSH_STEP:   crush_step = 64'(val[STEP_W-1:0]);
				default: ;
			endcase
		endfunction

		// exact product, round half up, drop sh bits, ceiling at 2^62
		static function longint unsigned mul_round(longint unsigned a, longint unsigned b,
				int sh);
			logic [127:0] prod;
			prod = {64'd0, a} * {64'd0, b};
			prod = (prod + (128'd1 << (sh - 1))) >> sh;
			return (prod > MAG_CEIL) ? MAG_CEIL : prod[63:0];
		endfunction

		static function longint mul_signed(longint a, longint unsigned b, int sh);
			longint unsigned m;
			longint r;
			m = mul_round((a < 0) ? -a : a, b, sh);
			r = m;
			return (a < 0) ? -r : r;
		endfunction

		static function longint unsigned peak_of(longint v);
			longint unsigned m;
			m = (v < 0) ? -v : v;
			return (m > SAMPLE_MAX) ? SAMPLE_MAX : m;
		endfunction

		function longint process_channel(longint x, longint unsigned pan_gain,
				inout longint unsigned in_pk, inout longint unsigned out_pk);
			longint v;
			longint unsigned pk;
			v = mul_signed(x, in_gain, GAIN_FRAC);
			pk = peak_of(v);
			if (pk > in_pk) in_pk = pk;
			v = mul_signed(v, pan_gain, PAN_FRAC);
			if (crush_enable) begin
				v = mul_signed(v, crush_scale, QNT_SHIFT);
				v = mul_signed(v, crush_step, STEP_SHIFT);
			end
			v = mul_signed(v, out_gain, GAIN_FRAC);
			if (v > SAMPLE_MAX) v = SAMPLE_MAX;
			if (v < SAMPLE_MIN) v = SAMPLE_MIN;
			pk = peak_of(v);
			if (pk > out_pk) out_pk = pk;
			return v;
		endfunction

		function void note_pair(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right,
				logic stereo, logic last);
			longint l, r, l_out, r_out;
			longint unsigned gl, gr;
			mix_word_t w;
			l = longint'($signed(left));
			r = stereo ? longint'($signed(right)) : l;
			gl = 64'(PAN_UNIT);
			gr = 64'(PAN_UNIT);
			if (!pan_bypass) begin
				if (pan_pos > 0) gl = 64'(PAN_UNIT - pan_pos);
				if (pan_pos < 0) gr = 64'(PAN_UNIT + pan_pos);
			end
			l_out = process_channel(l, gl, in_pk_l, out_pk_l);
			r_out = process_channel(r, gr, in_pk_r, out_pk_r);
			w = '0;
			w.left_out = l_out[SAMPLE_W-1:0];
			w.right_out = r_out[SAMPLE_W-1:0];
			if (last) begin
				w.in_peak_left = in_pk_l[PEAK_W-1:0];
				w.in_peak_right = in_pk_r[PEAK_W-1:0];
				w.out_peak_left = out_pk_l[PEAK_W-1:0];
				w.out_peak_right = out_pk_r[PEAK_W-1:0];
				w.peaks_valid = 1'b1;
				in_pk_l = 0;
				in_pk_r = 0;
				out_pk_l = 0;
				out_pk_r = 0;
			end
			pending.push_back(w);
		endfunction

		function void check_word(mix_word_t got);
			mix_word_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected output word %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
					got.in_peak_left !== want.in_peak_left ||
					got.in_peak_right !== want.in_peak_right ||
					got.out_peak_left !== want.out_peak_left ||
					got.out_peak_right !== want.out_peak_right ||
					got.peaks_valid !== want.peaks_valid) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("word mismatch: out L/R exp %h/%h got %h/%h, pv exp %b got %b",
						want.left_out, want.right_out, got.left_out, got.right_out,
						want.peaks_valid, got.peaks_valid);
					$display("  in peaks exp %h/%h got %h/%h, out peaks exp %h/%h got %h/%h",
						want.in_peak_left, want.in_peak_right,
						got.in_peak_left, got.in_peak_right,
						want.out_peak_left, want.out_peak_right,
						got.out_peak_left, got.out_peak_right);
				end
			end
		endfunction
	endclass

endpackage

[sim/tb_stereo_gain_pan_bitcrush.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_stereo_gain_pan_bitcrush
// Drives sample pairs through the stereo gain / pan / bit crush block under
// directed corner settings and then randomized register settings, with
// random gaps on the input and random stalls on the output, and checks every
// output word against the scoreboard's prediction.
// ---------------------------------------------------------------------------
module tb_stereo_gain_pan_bitcrush;

	import sgpb_pkg::*;
	import sgpb_tb_pkg::*;

	localparam int IDLE_LIMIT        = 1000;
	localparam int NUM_RANDOM_SETUPS = 14;
	localparam int PAIRS_PER_SETUP   = 60;
	localparam int DRAIN_CYCLES      = 20;

	localparam logic [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W - 1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	cfg_word_t              cfg_data = '0;

	mix_scoreboard sb;
	bit            tx_idle_on = 1'b1;
	bit            rx_idle_on = 1'b1;
	int            rx_hold = 1;
	int            rx_wait;
	int            idle_cycles = 0;
	mix_word_t     rx_word;

	always #2 clk = ~clk;

	stereo_gain_pan_bitcrush i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// output side: check each word, then stall the output at random while output stalls are on
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				rx_word.left_out       = m_axis_tdata[SAMPLE_W-1:0];
				rx_word.right_out      = m_axis_tdata[SAMPLE_W +: SAMPLE_W];
				rx_word.in_peak_left   = m_axis_tdata[2*SAMPLE_W +: PEAK_W];
				rx_word.in_peak_right  = m_axis_tdata[2*SAMPLE_W+PEAK_W +: PEAK_W];
				rx_word.out_peak_left  = m_axis_tdata[2*SAMPLE_W+2*PEAK_W +: PEAK_W];
				rx_word.out_peak_right = m_axis_tdata[2*SAMPLE_W+3*PEAK_W +: PEAK_W];
				rx_word.peaks_valid    = m_axis_tuser;
				sb.check_word(rx_word);
				rx_wait = rx_idle_on ? int'($urandom_range(0, 11)) : 0;
				if (rx_wait != 0) begin
					m_axis_tready <= 1'b0;
					rx_hold <= rx_wait;
				end
			end else if (rx_hold != 0) begin
				rx_hold <= rx_hold - 1;
				if (rx_hold == 1) m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic cfg_word_t rand_word();
		return cfg_word_t'({$urandom, $urandom});
	endfunction

	function automatic cfg_word_t pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return cfg_word_t'(GAIN_UNITY);
			2: return cfg_word_t'({GAIN_W{1'b1}});
			3: return rand_word();
			default: return cfg_word_t'($urandom_range(1 << 14, 1 << 17));
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return FULL_POS;
			1: return FULL_NEG;
			2: return SAMPLE_W'($urandom_range(0, 511) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_pair(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right,
			logic stereo, logic last);
		int gap;
		gap = tx_idle_on ? int'($urandom_range(0, 11)) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {right, left};
		s_axis_tuser <= stereo;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_pair(left, right, stereo, last);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, cfg_word_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic load_setup(cfg_word_t in_g, cfg_word_t out_g, cfg_word_t pan,
			cfg_word_t byp, cfg_word_t crush_on, cfg_word_t scale, cfg_word_t step);
		wait_drained();
		cfg_write(REG_IN_GAIN, in_g);
		cfg_write(REG_OUT_GAIN, out_g);
		cfg_write(REG_PAN_POSITION, pan);
		cfg_write(REG_PAN_BYPASS, byp);
		cfg_write(REG_CRUSH_ENABLE, crush_on);
		cfg_write(REG_CRUSH_SCALE, scale);
		cfg_write(REG_CRUSH_STEP, step);
		if ($urandom_range(0, 1) == 0) cfg_write(REG_SPARE, rand_word());
		cfg_valid <= 1'b0;
		tx_idle_on = $urandom_range(0, 3) != 0;
		rx_idle_on = $urandom_range(0, 3) != 0;
	endtask

	task automatic random_setup();
		cfg_word_t g_in, g_out, pan, scale, step;
		int bits;
		g_in = pick_gain();
		g_out = pick_gain();
		case ($urandom_range(0, 5))
			0: pan = cfg_word_t'(PAN_UNIT);
			1: pan = cfg_word_t'(-PAN_UNIT);
			2: pan = '0;
			3: pan = rand_word();
			default: pan = cfg_word_t'($urandom_range(0, 2 * PAN_UNIT) - PAN_UNIT);
		endcase
		// matched scale/step for a crush depth of 1..24 bits
		bits = int'($urandom_range(1, SAMPLE_W));
		scale = cfg_word_t'(64'd1 << (bits - 1 + SCALE_FRAC));
		step = cfg_word_t'(64'd1 << (STEP_FRAC + 1 - bits));
		case ($urandom_range(0, 9))
			0: scale = '0;
			1: step = '0;
			2: scale = cfg_word_t'($urandom);
			3: step = rand_word();
			4: begin
				scale = cfg_word_t'({SCALE_W{1'b1}});
				step = {STEP_W{1'b1}};
			end
			default: ;
		endcase
		load_setup(g_in, g_out, pan, cfg_word_t'($urandom_range(0, 3) == 0),
			cfg_word_t'($urandom_range(0, 2) != 0), scale, step);
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: unity path, full scale, mono copy, block end
		send_pair(FULL_POS, FULL_NEG, 1'b1, 1'b0);
		send_pair(FULL_NEG, FULL_POS, 1'b1, 1'b0);
		send_pair('0, '1, 1'b1, 1'b0);
		send_pair(FULL_POS, SAMPLE_W'(24'h00_1234), 1'b0, 1'b0);
		send_pair(FULL_NEG, FULL_POS, 1'b0, 1'b1);

		// max gains saturate, full right pan mutes left
		load_setup(cfg_word_t'({GAIN_W{1'b1}}), cfg_word_t'({GAIN_W{1'b1}}),
			cfg_word_t'(PAN_UNIT), '0, '0,
			cfg_word_t'(CRUSH_SCALE_RST), CRUSH_STEP_RST);
		send_pair(FULL_POS, FULL_NEG, 1'b1, 1'b0);
		send_pair(SAMPLE_W'(1), '1, 1'b1, 1'b1);
		send_pair(FULL_NEG, '0, 1'b0, 1'b1);

		// pan past full left clamps; 8-bit crush
		load_setup(cfg_word_t'(GAIN_UNITY), cfg_word_t'(GAIN_UNITY),
			cfg_word_t'(-2 * PAN_UNIT), '0, cfg_word_t'(1),
			cfg_word_t'(1 << 15), cfg_word_t'(1 << 25));
		send_pair(FULL_POS, FULL_NEG, 1'b1, 1'b0);
		send_pair(SAMPLE_W'(12345), SAMPLE_W'(-12345), 1'b1, 1'b0);
		send_pair(SAMPLE_W'(-40000), SAMPLE_W'(40000), 1'b1, 1'b0);
		send_pair(FULL_NEG, '0, 1'b0, 1'b1);

		// zero crush scale
		load_setup(cfg_word_t'(GAIN_UNITY), cfg_word_t'(3 << 15), '0, '0, cfg_word_t'(1),
			'0, cfg_word_t'(1 << 25));
		send_pair(FULL_POS, SAMPLE_W'(777), 1'b1, 1'b0);
		send_pair(SAMPLE_W'(-777), FULL_NEG, 1'b1, 1'b1);

		// zero crush step, pan set but bypassed
		load_setup(cfg_word_t'(2 << 16), cfg_word_t'(GAIN_UNITY), cfg_word_t'(40000),
			cfg_word_t'(1), cfg_word_t'(1), cfg_word_t'(1 << 15), '0);
		send_pair(SAMPLE_W'(99999), SAMPLE_W'(-5), 1'b1, 1'b0);
		send_pair(FULL_NEG, FULL_POS, 1'b1, 1'b1);

		// 1-bit crush, partial left pan
		load_setup(cfg_word_t'(GAIN_UNITY), cfg_word_t'(GAIN_UNITY), cfg_word_t'(-30000),
			'0, cfg_word_t'(1),
			cfg_word_t'(1 << SCALE_FRAC), cfg_word_t'(64'd1 << STEP_FRAC));
		send_pair(SAMPLE_W'(1 << 21), SAMPLE_W'(-(1 << 22)), 1'b1, 1'b0);
		send_pair(FULL_POS, FULL_NEG, 1'b1, 1'b0);
		send_pair(SAMPLE_W'(-3), SAMPLE_W'(3), 1'b0, 1'b1);

		repeat (NUM_RANDOM_SETUPS) begin
			random_setup();
			repeat (PAIRS_PER_SETUP)
				send_pair(pick_sample(), pick_sample(), $urandom_range(0, 3) != 0,
					$urandom_range(0, 7) == 0);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.errors += sb.pending.size();
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[files.f]
rtl/sgpb_pkg.sv
rtl/sgpb_cfg.sv
rtl/sgpb_ctrl.sv
rtl/sgpb_dp.sv
rtl/stereo_gain_pan_bitcrush.sv
sim/sgpb_tb_pkg.sv
sim/tb_stereo_gain_pan_bitcrush.sv
